>>> design/brdfss_pkg.sv
// shared constants, types and fixed point helpers for the split-sum brdf integrator
// the cosine table builder runs at elaboration only; no dependencies
package brdfss_pkg;

	localparam int N_SAMPLES    = 1024;           // power of two, 16..4096
	localparam int IDX_W        = $clog2(N_SAMPLES);
	localparam int OUT_SHIFT    = IDX_W + 14;      // divide by N_SAMPLES * 2^14
	localparam int ACC_W        = 34 + IDX_W;
	localparam int SQ_ST        = 31;              // root bits of the q30 square root
	localparam int DV_ST        = 32;              // quotient bits of the divider

	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	localparam longint unsigned PI_Q30 = 64'd3373259426;

	typedef logic [N_SAMPLES-1:0][31:0] cos_tab_t;

	// per-sample values riding along with the arithmetic units
	typedef struct packed {
		logic              setup;
		logic              last;
		logic              keep;
		logic              gsat;
		logic signed [31:0] cosv;
		logic [30:0]       cos_t;
		logic [30:0]       fc;
	} side_t;

	function automatic logic [33:0] qmul_w(input logic [32:0] a, input logic [32:0] b);
		logic [65:0] p;
		p = {33'b0, a} * {33'b0, b};
		return p[63:30];
	endfunction

	function automatic logic [30:0] qmul_n(input logic [32:0] a, input logic [32:0] b);
		logic [65:0] p;
		p = {33'b0, a} * {33'b0, b};
		return p[60:30];
	endfunction

	function automatic longint unsigned umul_c(input longint unsigned a,
			input longint unsigned b);
		return (a * b) >> 30;
	endfunction

	function automatic longint unsigned poly_sin_c(input longint unsigned x);
		longint unsigned x2;
		longint unsigned t;
		x2 = umul_c(x, x);
		t = (64'd1 << 30) - x2 / 72;
		t = (64'd1 << 30) - umul_c(x2, t) / 42;
		t = (64'd1 << 30) - umul_c(x2, t) / 20;
		t = (64'd1 << 30) - umul_c(x2, t) / 6;
		return umul_c(x, t);
	endfunction

	function automatic longint unsigned poly_cos_c(input longint unsigned x);
		longint unsigned x2;
		longint unsigned t;
		x2 = umul_c(x, x);
		t = (64'd1 << 30) - x2 / 90;
		t = (64'd1 << 30) - umul_c(x2, t) / 56;
		t = (64'd1 << 30) - umul_c(x2, t) / 30;
		t = (64'd1 << 30) - umul_c(x2, t) / 12;
		return (64'd1 << 30) - umul_c(x2, t) / 2;
	endfunction

	function automatic logic signed [31:0] cos_turn_c(input longint unsigned turn);
		longint unsigned quad;
		longint unsigned g;
		longint unsigned x;
		longint unsigned cg;
		longint unsigned sg;
		quad = (turn >> 30) & 64'd3;
		g = turn & 64'h3FFF_FFFF;
		if (g <= (64'd1 << 29)) begin
			x = (g * PI_Q30) >> 31;
			cg = poly_cos_c(x);
			sg = poly_sin_c(x);
		end else begin
			x = (((64'd1 << 30) - g) * PI_Q30) >> 31;
			cg = poly_sin_c(x);
			sg = poly_cos_c(x);
		end
		case (quad)
			64'd0: return 32'(cg);
			64'd1: return -32'(sg);
			64'd2: return -32'(cg);
			default: return 32'(sg);
		endcase
	endfunction

	function automatic cos_tab_t build_cos_tab();
		cos_tab_t t;
		longint unsigned turn;
		for (int i = 0; i < N_SAMPLES; i++) begin
			turn = (longint'(i) << 32) / N_SAMPLES;
			t[i] = cos_turn_c(turn);
		end
		return t;
	endfunction

endpackage

>>> design/brdf_split_sum_integrator.sv
// top level of the split-sum ggx environment brdf integrator
// uses brdfss_pkg, brdfss_div and brdfss_sqrt
//
// s_tdata carries one request: view cosine and roughness, both unsigned q0.16.
// m_tdata returns the integrated scale (a) and bias (b) terms, q0.16, saturated.
// one request is processed at a time; s_tready is high only while the engine
// is free. after acceptance the setup states compute k, alpha^2 and the view
// terms, then one hammersley sample enters the sample pipeline per cycle
// until N_SAMPLES samples have entered. the pipeline runs through a 32-stage
// divider, two 31-stage square roots, a second 32-stage divider and 12
// arithmetic stages. m_tvalid rises once the last sample is accumulated, and
// the engine is free again in that same cycle; a new request is not taken
// while the previous one is still in the pipeline.
// the finished result sits in the output register; a new request is taken
// while it waits. if the receiver still stalls when the next result is done,
// the engine holds it and stays busy until the output register frees up.
// reset clears all valid bits and returns the engine to idle with no result.
module brdf_split_sum_integrator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] view_cosine, [31:16] surface_roughness
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [15:0] scale_term, [31:16] bias_term
);
	import brdfss_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SET1  = 3'd1;
	localparam logic [2:0] ST_SET2  = 3'd2;
	localparam logic [2:0] ST_SET3  = 3'd3;
	localparam logic [2:0] ST_RUN   = 3'd4;
	localparam logic [2:0] ST_DRAIN = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	localparam cos_tab_t COS_TAB = build_cos_tab();

	logic [2:0]       state_q;
	logic [IDX_W-1:0] cnt_q;
	logic [15:0]      vin_q;
	logic [30:0]      v_q, r_q, k_q, vv_q, oma2_q, dt_q, dterm_q, vx_q;
	logic [ACC_W-1:0] acca_q, accb_q;
	logic             done_q;
	logic [15:0]      scale_q, bias_q;
	logic             mval_q;

	logic out_free;
	assign out_free = !mval_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);

	// ---------------- control and per-request setup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			mval_q  <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) mval_q <= 1'b1;
			else if (m_tready) mval_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (s_tvalid) state_q <= ST_SET1;
				ST_SET1: state_q <= ST_SET2;
				ST_SET2: state_q <= ST_SET3;
				ST_SET3: begin
					cnt_q   <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == IDX_W'(N_SAMPLES - 1)) state_q <= ST_DRAIN;
				end
				ST_DRAIN: if (done_q) state_q <= ST_FIN;
				ST_FIN: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (s_tvalid) begin
				vin_q <= s_tdata[15:0];
				v_q   <= {1'b0, s_tdata[15:0], 14'b0};
				r_q   <= {1'b0, s_tdata[31:16], 14'b0};
			end
			ST_SET1: begin
				k_q  <= qmul_n({2'b0, r_q}, {2'b0, r_q});
				vv_q <= qmul_n({2'b0, v_q}, {2'b0, v_q});
			end
			ST_SET2: begin
				oma2_q <= ONE_Q30 - qmul_n({2'b0, k_q}, {2'b0, k_q});
				dt_q   <= qmul_n({2'b0, v_q}, {2'b0, ONE_Q30 - k_q});
			end
			ST_SET3: dterm_q <= dt_q + k_q;
			default: ;
		endcase
	end

	// ---------------- s1: table read and radical inverse
	logic             v_s1, last_s1;
	logic [29:0]      y_s1;
	logic signed [31:0] cosv_s1;
	logic [29:0]      y_n;

	always_comb begin
		y_n = '0;
		for (int b = 0; b < IDX_W; b++) y_n[29-b] = cnt_q[b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= (state_q == ST_RUN);
	end

	always_ff @(posedge clk) begin
		y_s1    <= y_n;
		cosv_s1 <= COS_TAB[cnt_q];
		last_s1 <= (cnt_q == IDX_W'(N_SAMPLES - 1));
	end

	// ---------------- s2: ggx denominator product
	logic             v_s2, last_s2;
	logic [30:0]      p_s2, num_s2;
	logic signed [31:0] cosv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		p_s2    <= qmul_n({2'b0, oma2_q}, {3'b0, y_s1});
		num_s2  <= ONE_Q30 - {1'b0, y_s1};
		cosv_s2 <= cosv_s1;
		last_s2 <= last_s1;
	end

	// ---------------- cos^2(theta) = num / den
	logic [30:0] den;
	side_t       d1_side, d1_oside;
	logic        d1_ov;
	logic [31:0] d1_q;

	assign den = (ONE_Q30 == p_s2) ? 31'd1 : ONE_Q30 - p_s2;

	always_comb begin
		d1_side      = '0;
		d1_side.last = last_s2;
		d1_side.cosv = cosv_s2;
	end

	brdfss_div u_div_cos (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s2),
		.in_a     (num_s2),
		.in_d     (den),
		.in_side  (d1_side),
		.out_valid(d1_ov),
		.out_q    (d1_q),
		.out_side (d1_oside)
	);

	// ---------------- cos(theta); the setup slot computes the view sine
	logic        sq1_iv, sq1_ov;
	logic [30:0] sq1_x, sq1_root;
	side_t       sq1_side, sq1_oside;

	always_comb begin
		if (state_q == ST_SET2) begin
			sq1_iv         = 1'b1;
			sq1_x          = ONE_Q30 - vv_q;
			sq1_side       = '0;
			sq1_side.setup = 1'b1;
		end else begin
			sq1_iv   = d1_ov;
			sq1_x    = d1_q[30:0];
			sq1_side = d1_oside;
		end
	end

	brdfss_sqrt u_sqrt_cos (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sq1_iv),
		.in_x     (sq1_x),
		.in_side  (sq1_side),
		.out_valid(sq1_ov),
		.out_root (sq1_root),
		.out_side (sq1_oside)
	);

	always_ff @(posedge clk) begin
		if (sq1_ov && sq1_oside.setup) vx_q <= sq1_root;
	end

	// ---------------- s4: cos^2 for the sine
	logic        v_s4;
	logic [30:0] cc_s4;
	side_t       sd_s4, sd4_n;

	always_comb begin
		sd4_n       = sq1_oside;
		sd4_n.cos_t = sq1_root;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= sq1_ov && !sq1_oside.setup;
	end

	always_ff @(posedge clk) begin
		cc_s4 <= qmul_n({2'b0, sq1_root}, {2'b0, sq1_root});
		sd_s4 <= sd4_n;
	end

	logic        sq2_ov;
	logic [30:0] sin_t;
	side_t       sq2_oside;

	brdfss_sqrt u_sqrt_sin (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s4),
		.in_x     (ONE_Q30 - cc_s4),
		.in_side  (sd_s4),
		.out_valid(sq2_ov),
		.out_root (sin_t),
		.out_side (sq2_oside)
	);

	// ---------------- s5: half vector x and view dot cos part
	logic        v_s5, hneg_s5, last_s5;
	logic [30:0] hmag_s5, vc_s5, cost_s5;
	logic [31:0] cabs;

	assign cabs = sq2_oside.cosv[31] ? 32'(-sq2_oside.cosv) : 32'(sq2_oside.cosv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= sq2_ov;
	end

	always_ff @(posedge clk) begin
		hmag_s5 <= qmul_n({2'b0, sin_t}, {1'b0, cabs});
		hneg_s5 <= sq2_oside.cosv[31];
		vc_s5   <= qmul_n({2'b0, v_q}, {2'b0, sq2_oside.cos_t});
		cost_s5 <= sq2_oside.cos_t;
		last_s5 <= sq2_oside.last;
	end

	// ---------------- s6: v dot h (two's complement)
	logic        v_s6, last_s6;
	logic [33:0] vdh_s6;
	logic [30:0] cost_s6, m6;

	assign m6 = qmul_n({2'b0, vx_q}, {2'b0, hmag_s5});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		vdh_s6  <= hneg_s5 ? {3'b0, vc_s5} - {3'b0, m6} : {3'b0, vc_s5} + {3'b0, m6};
		cost_s6 <= cost_s5;
		last_s6 <= last_s5;
	end

	// ---------------- s7: light cosine product, clamp, gvis denominator
	logic        v_s7, mneg_s7, last_s7;
	logic [33:0] m_s7;
	logic [30:0] vh_s7, gden_s7;
	logic [33:0] vabs;

	assign vabs = vdh_s6[33] ? -vdh_s6 : vdh_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		m_s7    <= qmul_w(vabs[32:0], {2'b0, cost_s6});
		mneg_s7 <= vdh_s6[33];
		if (vdh_s6[33]) vh_s7 <= '0;
		else if (vdh_s6 > {3'b0, ONE_Q30}) vh_s7 <= ONE_Q30;
		else vh_s7 <= vdh_s6[30:0];
		gden_s7 <= qmul_n({2'b0, cost_s6}, {2'b0, dterm_q});
		last_s7 <= last_s6;
	end

	// ---------------- s8: sample mask, saturation check, 1 - vdoth
	logic        v_s8, keep_s8, gsat_s8, last_s8;
	logic [30:0] om_s8, vh_s8, gd_s8, gd_fix;

	assign gd_fix = (gden_s7 == '0) ? 31'd1 : gden_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		// light cosine 2*m - v is positive only for a positive product
		keep_s8 <= !mneg_s7 && ({m_s7, 1'b0} > {4'b0, v_q});
		gsat_s8 <= {2'b0, vh_s7} >= {gd_fix, 2'b0};
		om_s8   <= ONE_Q30 - vh_s7;
		vh_s8   <= vh_s7;
		gd_s8   <= gd_fix;
		last_s8 <= last_s7;
	end

	// ---------------- s9..s11: fresnel (1 - vdoth)^5
	logic        v_s9, v_s10, v_s11;
	logic [30:0] o2_s9, om_s9, o4_s10, om_s10, fc_s11;
	side_t       sd_s9, sd_s10, sd_s11, sd8_n;
	logic [30:0] vh_s9, vh_s10, vh_s11, gd_s9, gd_s10, gd_s11;

	always_comb begin
		sd8_n      = '0;
		sd8_n.keep = keep_s8;
		sd8_n.gsat = gsat_s8;
		sd8_n.last = last_s8;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else begin
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		o2_s9       <= qmul_n({2'b0, om_s8}, {2'b0, om_s8});
		om_s9       <= om_s8;
		sd_s9       <= sd8_n;
		vh_s9       <= vh_s8;
		gd_s9       <= gd_s8;

		o4_s10      <= qmul_n({2'b0, o2_s9}, {2'b0, o2_s9});
		om_s10      <= om_s9;
		sd_s10      <= sd_s9;
		vh_s10      <= vh_s9;
		gd_s10      <= gd_s9;

		fc_s11      <= qmul_n({2'b0, o4_s10}, {2'b0, om_s10});
		sd_s11      <= sd_s10;
		vh_s11      <= vh_s10;
		gd_s11      <= gd_s10;
	end

	side_t sd11_f;
	always_comb begin
		sd11_f    = sd_s11;
		sd11_f.fc = fc_s11;
	end

	// ---------------- gvis = vdoth / (ndoth * (v(1-k)+k))
	logic        d2_ov;
	logic [31:0] d2_q;
	side_t       d2_oside;

	brdfss_div u_div_gvis (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s11),
		.in_a     (vh_s11),
		.in_d     (gd_s11),
		.in_side  (sd11_f),
		.out_valid(d2_ov),
		.out_q    (d2_q),
		.out_side (d2_oside)
	);

	// ---------------- s12: weighted terms
	logic        v_s12, keep_s12, last_s12;
	logic [33:0] pa_s12, pb_s12;
	logic [31:0] gvis;

	assign gvis = d2_oside.gsat ? 32'hFFFF_FFFF : d2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s12 <= 1'b0;
		else v_s12 <= d2_ov;
	end

	always_ff @(posedge clk) begin
		pa_s12   <= qmul_w({2'b0, ONE_Q30 - d2_oside.fc}, {1'b0, gvis});
		pb_s12   <= qmul_w({2'b0, d2_oside.fc}, {1'b0, gvis});
		keep_s12 <= d2_oside.keep;
		last_s12 <= d2_oside.last;
	end

	// ---------------- s13: accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			acca_q <= '0;
			accb_q <= '0;
		end else begin
			done_q <= v_s12 && last_s12;
			if (state_q == ST_SET1) begin
				acca_q <= '0;
				accb_q <= '0;
			end else if (v_s12 && keep_s12) begin
				acca_q <= acca_q + ACC_W'(pa_s12);
				accb_q <= accb_q + ACC_W'(pb_s12);
			end
		end
	end

	// ---------------- output register
	logic [ACC_W-1:0] qa, qb;
	assign qa = acca_q >> OUT_SHIFT;
	assign qb = accb_q >> OUT_SHIFT;

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			if (vin_q == '0) begin
				scale_q <= '0;
				bias_q  <= '0;
			end else begin
				scale_q <= (|qa[ACC_W-1:16]) ? 16'hFFFF : qa[15:0];
				bias_q  <= (|qb[ACC_W-1:16]) ? 16'hFFFF : qb[15:0];
			end
		end
	end

	assign m_tvalid = mval_q;
	assign m_tdata  = {bias_q, scale_q};

	// ---------------- checks
	a_last_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_DRAIN)
		else $error("last sample reached the accumulator outside drain");

	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && mval_q && !m_tready) |=> state_q == ST_FIN)
		else $error("finished result left while output register was full");

	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_SET1 && !done_q))
		else $error("accepted request did not start setup cleanly");

endmodule

>>> design/brdfss_sqrt.sv
// pipelined q1.30 square root: root = floor(sqrt(x * 2^30)), one result bit per stage
// depends on brdfss_pkg for the stage count and the sideband type
module brdfss_sqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [30:0]        in_x,
	input  brdfss_pkg::side_t  in_side,
	output logic               out_valid,
	output logic [30:0]        out_root,
	output brdfss_pkg::side_t  out_side
);
	import brdfss_pkg::*;

	logic        vld_s  [SQ_ST];
	logic [33:0] rem_s  [SQ_ST];
	logic [30:0] root_s [SQ_ST];
	logic [30:0] x_s    [SQ_ST];
	side_t       sd_s   [SQ_ST];

	logic [33:0] rem_n  [SQ_ST];
	logic [30:0] root_n [SQ_ST];

	always_comb begin
		logic [33:0] prem;
		logic [30:0] proot;
		logic [30:0] px;
		logic [61:0] n;
		logic [33:0] r4;
		logic [33:0] trial;
		for (int j = 0; j < SQ_ST; j++) begin
			if (j == 0) begin
				prem  = '0;
				proot = '0;
				px    = in_x;
			end else begin
				prem  = rem_s[j-1];
				proot = root_s[j-1];
				px    = x_s[j-1];
			end
			n     = {1'b0, px, 30'b0};
			r4    = {prem[31:0], n[2*(SQ_ST-1-j)+1 -: 2]};
			trial = {1'b0, proot, 2'b01};
			if (r4 >= trial) begin
				rem_n[j]  = r4 - trial;
				root_n[j] = {proot[29:0], 1'b1};
			end else begin
				rem_n[j]  = r4;
				root_n[j] = {proot[29:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < SQ_ST; j++) vld_s[j] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
			for (int j = 1; j < SQ_ST; j++) vld_s[j] <= vld_s[j-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < SQ_ST; j++) begin
			rem_s[j]  <= rem_n[j];
			root_s[j] <= root_n[j];
		end
		x_s[0]  <= in_x;
		sd_s[0] <= in_side;
		for (int j = 1; j < SQ_ST; j++) begin
			x_s[j]  <= x_s[j-1];
			sd_s[j] <= sd_s[j-1];
		end
	end

	assign out_valid = vld_s[SQ_ST-1];
	assign out_root  = root_s[SQ_ST-1];
	assign out_side  = sd_s[SQ_ST-1];

endmodule

>>> design/brdfss_div.sv
// pipelined divider: q = floor(a * 2^30 / d), one quotient bit per stage
// needs a/4 < d so the quotient fits 32 bits; depends on brdfss_pkg
module brdfss_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [30:0]        in_a,
	input  logic [30:0]        in_d,
	input  brdfss_pkg::side_t  in_side,
	output logic               out_valid,
	output logic [31:0]        out_q,
	output brdfss_pkg::side_t  out_side
);
	import brdfss_pkg::*;

	logic        vld_s [DV_ST];
	logic [30:0] rem_s [DV_ST];
	logic [31:0] q_s   [DV_ST];
	logic [30:0] d_s   [DV_ST];
	logic [1:0]  lo_s  [DV_ST];
	side_t       sd_s  [DV_ST];

	logic [30:0] rem_n [DV_ST];
	logic [31:0] q_n   [DV_ST];

	always_comb begin
		logic [30:0] prem;
		logic [31:0] pq;
		logic [30:0] pd;
		logic [1:0]  plo;
		logic        nb;
		logic [31:0] r2;
		for (int j = 0; j < DV_ST; j++) begin
			if (j == 0) begin
				prem = {2'b0, in_a[30:2]};
				pq   = '0;
				pd   = in_d;
				plo  = in_a[1:0];
			end else begin
				prem = rem_s[j-1];
				pq   = q_s[j-1];
				pd   = d_s[j-1];
				plo  = lo_s[j-1];
			end
			// low dividend bits: a[1:0] then zeros
			nb = (j < 2) ? plo[1 - (j % 2)] : 1'b0;
			r2 = {prem, nb};
			if (r2 >= {1'b0, pd}) begin
				rem_n[j] = 31'(r2 - {1'b0, pd});
				q_n[j]   = {pq[30:0], 1'b1};
			end else begin
				rem_n[j] = r2[30:0];
				q_n[j]   = {pq[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < DV_ST; j++) vld_s[j] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
			for (int j = 1; j < DV_ST; j++) vld_s[j] <= vld_s[j-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < DV_ST; j++) begin
			rem_s[j] <= rem_n[j];
			q_s[j]   <= q_n[j];
		end
		d_s[0]  <= in_d;
		lo_s[0] <= in_a[1:0];
		sd_s[0] <= in_side;
		for (int j = 1; j < DV_ST; j++) begin
			d_s[j]  <= d_s[j-1];
			lo_s[j] <= lo_s[j-1];
			sd_s[j] <= sd_s[j-1];
		end
	end

	assign out_valid = vld_s[DV_ST-1];
	assign out_q     = q_s[DV_ST-1];
	assign out_side  = sd_s[DV_ST-1];

endmodule
